FILE: sv/contiguous_slot_allocator_top_defines.svh
// Assertion macros shared by the slot allocator RTL.
// No dependencies; modules using these must have clk and rst_n in scope.
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/csa_pkg.sv
// Package for the contiguous slot allocator: item types, codes, control structs.
// No dependencies.
`default_nettype none

package csa_pkg;

    // Slots held in one map word
    localparam int MAP_WORD_W = 8;
    localparam int WORD_BITS  = 3;

    // Command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BAD      = 2'd2;

    typedef struct packed {
        logic       command;
        logic [8:0] count;
        logic [7:0] start_index;
    } csa_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] first_slot;
    } csa_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic check;
        logic scan_rd;
        logic scan_ev;
        logic fill_rd;
        logic fill_wr;
    } csa_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;
        logic release_req;
        logic too_big;
        logic past_end;
        logic found;
        logic last_word;
        logic fill_last;
    } csa_sts_t;

endpackage

`default_nettype wire

FILE: sv/contiguous_slot_allocator_top.sv
// An allocate scans map words for a fit after the check state; a found run or a released
// range is filled by word; each 8-slot map word gets a read then an evaluate/write state.
// Zero-count, oversize and out-of-range requests go from check straight to the response.
// One item at a time: busy stays high until the result strobe; the receiver cannot stall.
// Asynchronous active-low reset: every slot free, block idle, no clearing pass.
// Depends on csa_pkg, csa_ctrl, csa_datapath and csa_ram.
`default_nettype none

module contiguous_slot_allocator_top #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire csa_pkg::csa_req_t request,
    output logic                   busy,
    output logic                   done,
    output csa_pkg::csa_rsp_t      result
);

    import csa_pkg::*;

    csa_ctl_t ctl;
    csa_sts_t sts;

    // Sequencer
    csa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // Map and scan logic
    csa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (request),
        .sts   (sts),
        .rsp   (result)
    );

endmodule

`default_nettype wire

FILE: sv/csa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/csa_ctrl.sv
// Controller state machine of the slot allocator.
// Depends on csa_pkg and contiguous_slot_allocator_top_defines.svh.
`default_nettype none
`include "contiguous_slot_allocator_top_defines.svh"

module csa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire csa_pkg::csa_sts_t sts,
    output csa_pkg::csa_ctl_t      ctl,
    output logic                   busy,
    output logic                   done
);

    import csa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CHECK   = 7'b0000010,
        S_SCAN_RD = 7'b0000100,
        S_SCAN_EV = 7'b0001000,
        S_FILL_RD = 7'b0010000,
        S_FILL_WR = 7'b0100000,
        S_RESP    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_RESP;
                end
                else if (sts.release_req)
                begin
                    state_next = sts.past_end ? S_RESP : S_FILL_RD;
                end
                else
                begin
                    state_next = sts.too_big ? S_RESP : S_SCAN_RD;
                end
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                if (sts.found)
                begin
                    state_next = S_FILL_RD;
                end
                else if (sts.last_word)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FILL_RD: state_next = S_FILL_WR;
            S_FILL_WR: state_next = sts.fill_last ? S_RESP : S_FILL_RD;
            S_RESP:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode
    assign ctl.load    = (state_reg == S_IDLE) && start;
    assign ctl.check   = (state_reg == S_CHECK);
    assign ctl.scan_rd = (state_reg == S_SCAN_RD);
    assign ctl.scan_ev = (state_reg == S_SCAN_EV);
    assign ctl.fill_rd = (state_reg == S_FILL_RD);
    assign ctl.fill_wr = (state_reg == S_FILL_WR);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

    `CSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `CSA_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe not a single cycle")
    `CSA_ASSERT_NEXT(a_scan_pairs, ctl.scan_rd, ctl.scan_ev, "scan read not followed by evaluate")

endmodule

`default_nettype wire

FILE: sv/csa_datapath.sv
// Datapath of the slot allocator: map RAM, first-fit word scan, range fill.
// Depends on csa_pkg, csa_ram and contiguous_slot_allocator_top_defines.svh.
`default_nettype none
`include "contiguous_slot_allocator_top_defines.svh"

module csa_datapath #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csa_pkg::csa_ctl_t ctl,
    input  wire csa_pkg::csa_req_t req,
    output csa_pkg::csa_sts_t      sts,
    output csa_pkg::csa_rsp_t      rsp
);

    import csa_pkg::*;

    localparam int WORDS = SLOT_COUNT / MAP_WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = $clog2(SLOT_COUNT);
    localparam int RW    = $clog2(SLOT_COUNT + 1);
    localparam int SW    = (IW + 1 > 10) ? IW + 1 : 10;

    csa_req_t             req_reg, req_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [RW-1:0]        run_reg, run_next;
    logic [IW-1:0]        lo_reg, lo_next;
    logic [IW-1:0]        hi_reg, hi_next;
    logic                 set_reg, set_next;
    csa_rsp_t             rsp_reg, rsp_next;
    logic [WORDS-1:0]     valid_reg;
    logic                 rd_valid_reg;

    logic [MAP_WORD_W-1:0] rdata;
    logic [MAP_WORD_W-1:0] word;
    logic [MAP_WORD_W-1:0] mask;
    logic [MAP_WORD_W-1:0] wdata;

    logic [SW-1:0]        cnt_sw;
    logic [SW-1:0]        rel_end_sw;
    logic [SW-1:0]        word_base_sw;
    logic [SW-1:0]        end_sw;
    logic [SW-1:0]        first_sw;
    logic [SW-1:0]        scan_run;
    logic                 scan_hit;
    logic [WORD_BITS-1:0] hit_pos;

    // Map storage, one word per MAP_WORD_W slots
    csa_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ctl.fill_wr),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Never-written words read as all free
    assign word = rdata & {MAP_WORD_W{rd_valid_reg}};

    // Request checks
    assign cnt_sw       = SW'(req_reg.count);
    assign rel_end_sw   = SW'(req_reg.start_index) + cnt_sw;
    assign word_base_sw = SW'(idx_reg) << WORD_BITS;

    assign sts.cnt_zero    = (req_reg.count == 9'd0);
    assign sts.release_req = (req_reg.command == CMD_RELEASE);
    assign sts.too_big     = (cnt_sw > SW'(SLOT_COUNT));
    assign sts.past_end    = (rel_end_sw > SW'(SLOT_COUNT));
    assign sts.last_word   = (idx_reg == AW'(WORDS - 1));
    assign sts.fill_last   = (idx_reg == AW'(hi_reg >> WORD_BITS));
    assign sts.found       = scan_hit;

    // Free-run count across one word, stops at the first bit completing the run
    always_comb
    begin
        logic [SW-1:0]        r;
        logic                 hit;
        logic [WORD_BITS-1:0] pos;
        r   = SW'(run_reg);
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < MAP_WORD_W; j++)
        begin
            if (!hit)
            begin
                r = word[j] ? '0 : r + SW'(1);
                if (r == cnt_sw)
                begin
                    hit = 1'b1;
                    pos = WORD_BITS'(j);
                end
            end
        end
        scan_run = r;
        scan_hit = hit;
        hit_pos  = pos;
    end

    assign end_sw   = word_base_sw + SW'(hit_pos);
    assign first_sw = end_sw + SW'(1) - cnt_sw;

    // Bits of the current word inside [lo, hi]
    always_comb
    begin
        logic [SW-1:0] pos;
        for (int b = 0; b < MAP_WORD_W; b++)
        begin
            pos     = word_base_sw + SW'(b);
            mask[b] = (pos >= SW'(lo_reg)) && (pos <= SW'(hi_reg));
        end
    end

    assign wdata = set_reg ? (word | mask) : (word & ~mask);

    // Register next values
    always_comb
    begin
        req_next = req_reg;
        idx_next = idx_reg;
        run_next = run_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        set_next = set_reg;
        rsp_next = rsp_reg;
        if (ctl.load)
        begin
            req_next = req;
        end
        if (ctl.check)
        begin
            rsp_next.first_slot = '0;
            rsp_next.status     = STATUS_DONE;
            if (sts.cnt_zero)
            begin
                rsp_next.status = STATUS_BAD;
            end
            else if (sts.release_req)
            begin
                if (sts.past_end)
                begin
                    rsp_next.status = STATUS_BAD;
                end
                else
                begin
                    lo_next  = IW'(req_reg.start_index);
                    hi_next  = IW'(rel_end_sw - SW'(1));
                    set_next = 1'b0;
                    idx_next = AW'(IW'(req_reg.start_index) >> WORD_BITS);
                end
            end
            else if (sts.too_big)
            begin
                rsp_next.status = STATUS_NO_SPACE;
            end
            else
            begin
                idx_next = '0;
                run_next = '0;
            end
        end
        if (ctl.scan_ev)
        begin
            if (scan_hit)
            begin
                lo_next             = IW'(first_sw);
                hi_next             = IW'(end_sw);
                set_next            = 1'b1;
                idx_next            = AW'(IW'(first_sw) >> WORD_BITS);
                rsp_next.status     = STATUS_DONE;
                rsp_next.first_slot = first_sw[7:0];
            end
            else if (sts.last_word)
            begin
                rsp_next.status     = STATUS_NO_SPACE;
                rsp_next.first_slot = '0;
            end
            else
            begin
                idx_next = idx_reg + AW'(1);
                run_next = RW'(scan_run);
            end
        end
        if (ctl.fill_wr && !sts.fill_last)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            run_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            set_reg      <= 1'b0;
            rsp_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            run_reg <= run_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            set_reg <= set_next;
            rsp_reg <= rsp_next;
            if (ctl.scan_rd || ctl.fill_rd)
            begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
            if (ctl.fill_wr)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Request payload register
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign rsp = rsp_reg;

    `CSA_ASSERT_SAME(a_slot_zero, rsp_reg.status != STATUS_DONE, rsp_reg.first_slot == 8'd0,
        "first_slot nonzero on a failed request")
    `CSA_ASSERT_SAME(a_hit_order, ctl.scan_ev && scan_hit, first_sw <= end_sw,
        "found run starts after its end")
    `CSA_ASSERT_SAME(a_fill_range, ctl.fill_wr, idx_reg <= AW'(hi_reg >> WORD_BITS),
        "fill write beyond the last word of the run")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for contiguous_slot_allocator_top: directed table, then random traffic.
// Predicts every item on its own copy of the slot map; depends on csa_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import csa_pkg::*;

    localparam int SLOTS          = 256;
    localparam int N_DIRECTED     = 23;
    localparam int RANDOM_ITEMS   = 530;
    localparam int WATCHDOG_LIMIT = 2000;
    // Longest item scans all 32 map words and fills all 32; the drain time has margin beyond it
    localparam int DRAIN_CYCLES   = 150;

    // One row of the directed table; when typed is set the row's status and
    // first_slot are the expected result, otherwise the slot map predicts it
    typedef struct packed {
        logic       command;
        logic [8:0] count;
        logic [7:0] start_index;
        logic       typed;
        logic [1:0] status;
        logic [7:0] first_slot;
    } directed_row_t;

    // A run handed out by the block and not yet released
    typedef struct packed {
        logic [7:0] first;
        logic [8:0] len;
    } run_t;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    csa_req_t request = '0;
    logic     busy;
    logic     done;
    csa_rsp_t result;

    logic [SLOTS-1:0] model_used = '0;
    csa_rsp_t         pending_responses [$];
    run_t             live_runs [$];
    csa_rsp_t         oldest;
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        // zero count, oversize allocate, release past the end
        '{CMD_ALLOC,     9'd0,   8'd0,   1'b1, STATUS_BAD,      8'd0},
        '{CMD_RELEASE,   9'd0,   8'd7,   1'b1, STATUS_BAD,      8'd0},
        '{CMD_ALLOC,     9'd257, 8'd0,   1'b1, STATUS_NO_SPACE, 8'd0},
        '{CMD_ALLOC,     9'd511, 8'd255, 1'b1, STATUS_NO_SPACE, 8'd0},
        '{CMD_RELEASE,   9'd2,   8'd255, 1'b1, STATUS_BAD,      8'd0},
        '{CMD_RELEASE,   9'd256, 8'd1,   1'b1, STATUS_BAD,      8'd0},
        // first allocations after reset; start_index is ignored
        '{CMD_ALLOC,     9'd1,   8'd255, 1'b1, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd3,   8'd0,   1'b1, STATUS_DONE,     8'd1},
        '{CMD_RELEASE,   9'd1,   8'd0,   1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd1,   8'd0,   1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd4,   8'd0,   1'b0, STATUS_DONE,     8'd0},
        // whole pool released, then released again while already free
        '{CMD_RELEASE,   9'd256, 8'd0,   1'b0, STATUS_DONE,     8'd0},
        '{CMD_RELEASE,   9'd256, 8'd0,   1'b0, STATUS_DONE,     8'd0},
        // whole pool in one run, then a full map
        '{CMD_ALLOC,     9'd256, 8'd170, 1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd1,   8'd0,   1'b1, STATUS_NO_SPACE, 8'd0},
        '{CMD_RELEASE,   9'd1,   8'd255, 1'b1, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd1,   8'd0,   1'b0, STATUS_DONE,     8'd0},
        // a hole in the middle and one at the top: first fit and no fit
        '{CMD_RELEASE,   9'd10,  8'd100, 1'b0, STATUS_DONE,     8'd0},
        '{CMD_RELEASE,   9'd1,   8'd255, 1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd11,  8'd0,   1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd10,  8'd85,  1'b0, STATUS_DONE,     8'd0},
        '{CMD_ALLOC,     9'd1,   8'd0,   1'b0, STATUS_DONE,     8'd0},
        '{CMD_RELEASE,   9'd256, 8'd0,   1'b0, STATUS_DONE,     8'd0}
    };

    contiguous_slot_allocator_top #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one item to the slot map and returns the result it should give
    function automatic csa_rsp_t apply_to_slot_map(input csa_req_t req);
        csa_rsp_t rsp;
        int       run_len;
        int       lo;
        rsp.status     = STATUS_DONE;
        rsp.first_slot = '0;
        run_len        = 0;
        if (req.count == 0)
            rsp.status = STATUS_BAD;
        else if (req.command == CMD_ALLOC)
        begin
            rsp.status = STATUS_NO_SPACE;
            if (int'(req.count) <= SLOTS)
            begin
                // first fit: lowest run of count free slots
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (model_used[i])
                        run_len = 0;
                    else
                    begin
                        run_len++;
                        if (run_len == int'(req.count) && rsp.status != STATUS_DONE)
                        begin
                            lo = i + 1 - int'(req.count);
                            for (int k = lo; k <= i; k++)
                                model_used[k] = 1'b1;
                            rsp.status     = STATUS_DONE;
                            rsp.first_slot = lo[7:0];
                        end
                    end
                end
            end
        end
        else if (int'(req.start_index) + int'(req.count) > SLOTS)
            rsp.status = STATUS_BAD;
        else
        begin
            // slots already free simply stay free
            for (int i = int'(req.start_index); i < int'(req.start_index) + int'(req.count); i++)
                model_used[i] = 1'b0;
        end
        return rsp;
    endfunction

    // Presents one item from a falling edge until accepted, records what it should
    // give, and returns at the next falling edge with start still high
    task automatic send_item(input csa_req_t req, input logic use_typed,
                             input csa_rsp_t typed_rsp);
        csa_rsp_t predicted;
        run_t     run;
        request <= req;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_to_slot_map(req);
        pending_responses.push_back(use_typed ? typed_rsp : predicted);
        if (req.command == CMD_ALLOC && predicted.status == STATUS_DONE)
        begin
            run.first = predicted.first_slot;
            run.len   = req.count;
            live_runs.push_back(run);
        end
        @(negedge clk);
    endtask

    // Result checker: every strobe is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d first_slot %0d",
                         $realtime, result.status, result.first_slot);
                mismatch_count++;
            end
            else
            begin
                oldest = pending_responses.pop_front();
                if (result.status !== oldest.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, oldest.status, result.status);
                    mismatch_count++;
                end
                if (result.first_slot !== oldest.first_slot)
                begin
                    $display("%0t: first_slot expected %0d actual %0d",
                             $realtime, oldest.first_slot, result.first_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no item taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        directed_row_t row;
        csa_req_t      req;
        csa_rsp_t      typed_rsp;
        run_t          run;
        int            total;
        int            burst_len;
        int            sel;
        int            pick;
        int            idx;
        int            off;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, back to back
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row                  = directed_rows[r];
            req.command          = row.command;
            req.count            = row.count;
            req.start_index      = row.start_index;
            typed_rsp.status     = row.status;
            typed_rsp.first_slot = row.first_slot;
            send_item(req, row.typed, typed_rsp);
        end
        live_runs.delete();

        // Random traffic: mostly allocate and release of live runs, some noise
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            for (int b = 0; b < burst_len && total < RANDOM_ITEMS; b++)
            begin
                sel             = $urandom_range(0, 99);
                req.command     = CMD_ALLOC;
                req.start_index = 8'($urandom_range(0, 255));
                req.count       = 9'd1;
                if (sel < 45)
                begin
                    // mostly small runs, a few large or oversize
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        req.count = 9'($urandom_range(1, 8));
                    else if (pick < 90)
                        req.count = 9'($urandom_range(9, 48));
                    else if (pick < 97)
                        req.count = 9'($urandom_range(49, 256));
                    else
                        req.count = 9'($urandom_range(257, 511));
                end
                else if (sel < 82 && live_runs.size() != 0)
                begin
                    // give back a live run, sometimes only part of it
                    idx = $urandom_range(0, live_runs.size() - 1);
                    run = live_runs[idx];
                    live_runs.delete(idx);
                    req.command     = CMD_RELEASE;
                    req.start_index = run.first;
                    req.count       = run.len;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        off             = $urandom_range(0, int'(run.len) - 1);
                        req.start_index = 8'(int'(run.first) + off);
                        req.count       = 9'($urandom_range(1, int'(run.len) - off));
                    end
                end
                else if (sel < 92)
                begin
                    // arbitrary release, now and then past the end
                    req.command = CMD_RELEASE;
                    if ($urandom_range(0, 4) == 0)
                        req.count = 9'($urandom_range(1, 511));
                    else
                        req.count = 9'($urandom_range(1, SLOTS - int'(req.start_index)));
                end
                else if (sel < 96)
                begin
                    req.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_ALLOC;
                    req.count   = '0;
                end
                else if (sel < 98)
                begin
                    // clear the whole pool
                    req.command     = CMD_RELEASE;
                    req.start_index = '0;
                    req.count       = 9'(SLOTS);
                    live_runs.delete();
                end
                else
                    req.count = 9'($urandom_range(1, 256));
                send_item(req, 1'b0, '0);
                total++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
        if (start)
            start <= 1'b0;

        // Drain, then give a stray result time to show up
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/csa_pkg.sv
sv/csa_ram.sv
sv/csa_ctrl.sv
sv/csa_datapath.sv
sv/contiguous_slot_allocator_top.sv
dv/tb.sv
